@@ sv/mcg_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the motion collision guard.
// No dependencies; used by mcg_csr, mcg_decide and motion_collision_guard.
package mcg_pkg;

   // Sensor state codes as they arrive from the range sensors.
   localparam logic [1:0] ST_VALID = 2'd0;
   localparam logic [1:0] ST_CLEAR = 2'd1;

   // Sensor numbers reported in deciding_sensor.
   localparam logic [2:0] SNS_FRONT_LEFT  = 3'd0;
   localparam logic [2:0] SNS_FRONT_RIGHT = 3'd1;
   localparam logic [2:0] SNS_REAR_CENTER = 3'd2;
   localparam logic [2:0] SNS_REAR_LEFT   = 3'd3;
   localparam logic [2:0] SNS_REAR_RIGHT  = 3'd4;
   localparam logic [2:0] SNS_NONE        = 3'd5;
   localparam logic [2:0] SNS_GROUP       = 3'd6;

   // Guard modes.
   localparam logic [2:0] MODE_IDLE          = 3'd0;
   localparam logic [2:0] MODE_FORWARD       = 3'd1;
   localparam logic [2:0] MODE_REVERSE       = 3'd2;
   localparam logic [2:0] MODE_REVERSE_LEFT  = 3'd3;
   localparam logic [2:0] MODE_REVERSE_RIGHT = 3'd4;
   localparam logic [2:0] MODE_ROTATE_LEFT   = 3'd5;
   localparam logic [2:0] MODE_ROTATE_RIGHT  = 3'd6;

   // Guard actions.
   localparam logic [1:0] ACT_PASS = 2'd0;
   localparam logic [1:0] ACT_SLOW = 2'd1;
   localparam logic [1:0] ACT_STOP = 2'd2;

   // Reason codes.
   localparam logic [2:0] RSN_OK     = 3'd0;
   localparam logic [2:0] RSN_CLEAR  = 3'd1;
   localparam logic [2:0] RSN_SLOW   = 3'd2;
   localparam logic [2:0] RSN_STOP   = 3'd3;
   localparam logic [2:0] RSN_ALLINV = 3'd4;

   // Register indexes on the configuration port.
   localparam logic [2:0] REG_DRIVE_BAND          = 3'd0;
   localparam logic [2:0] REG_TURN_BAND           = 3'd1;
   localparam logic [2:0] REG_REVERSE_STOP_DIST   = 3'd2;
   localparam logic [2:0] REG_REVERSE_SLOW_DIST   = 3'd3;
   localparam logic [2:0] REG_REVERSE_SPEED_LIMIT = 3'd4;
   localparam logic [2:0] REG_ROTATE_STOP_DIST    = 3'd5;
   localparam logic [2:0] REG_ROTATE_SLOW_DIST    = 3'd6;
   localparam logic [2:0] REG_ROTATE_SPEED_LIMIT  = 3'd7;

   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth  = 16;

   // Configuration register file contents.
   typedef struct packed {
      logic [14:0] drive_band;
      logic [14:0] turn_band;
      logic [15:0] reverse_stop_dist;
      logic [15:0] reverse_slow_dist;
      logic [14:0] reverse_speed_limit;
      logic [15:0] rotate_stop_dist;
      logic [15:0] rotate_slow_dist;
      logic [14:0] rotate_speed_limit;
   } cfg_type;

   // One command and sensor snapshot.
   typedef struct packed {
      logic signed [15:0] linear_velocity;
      logic signed [15:0] angular_velocity;
      logic [1:0]         front_left_state;
      logic [15:0]        front_left_dist;
      logic [1:0]         front_right_state;
      logic [15:0]        front_right_dist;
      logic [1:0]         rear_center_state;
      logic [15:0]        rear_center_dist;
      logic [1:0]         rear_left_state;
      logic [15:0]        rear_left_dist;
      logic [1:0]         rear_right_state;
      logic [15:0]        rear_right_dist;
   } req_type;

   // One guarded result.
   typedef struct packed {
      logic signed [15:0] gated_linear;
      logic signed [15:0] gated_angular;
      logic [2:0]         guard_mode;
      logic [1:0]         guard_action;
      logic               blocked;
      logic [2:0]         deciding_sensor;
      logic [15:0]        nearest_dist;
      logic               dist_known;
      logic [2:0]         reason;
   } rsp_type;

endpackage

@@ sv/mcg_csr.sv @@
`timescale 1ns / 1ps
// Configuration register file of the motion collision guard.
// Depends on mcg_pkg for the register indexes and cfg_type.
module mcg_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mcg_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [mcg_pkg::CsrDataWidth-1:0]    csr_wdata,
   output mcg_pkg::cfg_type                    cfg
);
   import mcg_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Writes complete in the cycle they are offered.
   assign csr_ready = 1'b1;

   // Decode the register index and update the addressed field.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_DRIVE_BAND:          cfg_in.drive_band          = csr_wdata[14:0];
            REG_TURN_BAND:           cfg_in.turn_band           = csr_wdata[14:0];
            REG_REVERSE_STOP_DIST:   cfg_in.reverse_stop_dist   = csr_wdata;
            REG_REVERSE_SLOW_DIST:   cfg_in.reverse_slow_dist   = csr_wdata;
            REG_REVERSE_SPEED_LIMIT: cfg_in.reverse_speed_limit = csr_wdata[14:0];
            REG_ROTATE_STOP_DIST:    cfg_in.rotate_stop_dist    = csr_wdata;
            REG_ROTATE_SLOW_DIST:    cfg_in.rotate_slow_dist    = csr_wdata;
            REG_ROTATE_SPEED_LIMIT:  cfg_in.rotate_speed_limit  = csr_wdata[14:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   // Register file with its power-on values.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.drive_band          <= 15'd10;
         cfg_ff.turn_band           <= 15'd50;
         cfg_ff.reverse_stop_dist   <= 16'd200;
         cfg_ff.reverse_slow_dist   <= 16'd500;
         cfg_ff.reverse_speed_limit <= 15'd100;
         cfg_ff.rotate_stop_dist    <= 16'd150;
         cfg_ff.rotate_slow_dist    <= 16'd400;
         cfg_ff.rotate_speed_limit  <= 15'd300;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ sv/mcg_decide.sv @@
`timescale 1ns / 1ps
// Combinational guard decision for one command and sensor snapshot.
// Depends on mcg_pkg for req_type, cfg_type, rsp_type and the code constants.
module mcg_decide #(
   parameter int BACKUP_BAND = 10
) (
   input  mcg_pkg::req_type req,
   input  mcg_pkg::cfg_type cfg,
   output mcg_pkg::rsp_type rsp
);
   import mcg_pkg::*;

   localparam int RevFloorInt = -BACKUP_BAND;
   localparam logic signed [16:0] RevFloor = signed'(17'(RevFloorInt));

   logic signed [16:0] lin17;
   logic signed [16:0] ang17;
   logic [16:0]        alin;
   logic [16:0]        aang;
   logic signed [16:0] rot_db;
   logic               rotating;
   logic               reversing;
   logic               left;

   // Candidate sensors of the checked group, in priority order.
   logic [1:0]  slot_st [3];
   logic [15:0] slot_dist [3];
   logic [2:0]  slot_id [3];
   logic        slot_en [3];

   always_comb begin
      lin17     = {req.linear_velocity[15], req.linear_velocity};
      ang17     = {req.angular_velocity[15], req.angular_velocity};
      alin      = lin17[16] ? 17'(-lin17) : 17'(lin17);
      aang      = ang17[16] ? 17'(-ang17) : 17'(ang17);
      rot_db    = signed'({2'b00, cfg.turn_band});
      rotating  = (alin < {2'b00, cfg.drive_band}) &&
                  (aang > {2'b00, cfg.turn_band});
      reversing = lin17 < RevFloor;
      left      = ang17 > 17'sd0;
   end

   // Pick the sensors to check: the turning side, or the three rear ones.
   always_comb begin
      if (rotating) begin
         slot_st[0]   = left ? req.front_left_state : req.front_right_state;
         slot_dist[0] = left ? req.front_left_dist  : req.front_right_dist;
         slot_id[0]   = left ? SNS_FRONT_LEFT       : SNS_FRONT_RIGHT;
         slot_st[1]   = left ? req.rear_left_state  : req.rear_right_state;
         slot_dist[1] = left ? req.rear_left_dist   : req.rear_right_dist;
         slot_id[1]   = left ? SNS_REAR_LEFT        : SNS_REAR_RIGHT;
      end else begin
         slot_st[0]   = req.rear_center_state;
         slot_dist[0] = req.rear_center_dist;
         slot_id[0]   = SNS_REAR_CENTER;
         slot_st[1]   = req.rear_left_state;
         slot_dist[1] = req.rear_left_dist;
         slot_id[1]   = SNS_REAR_LEFT;
      end
      slot_st[2]   = req.rear_right_state;
      slot_dist[2] = req.rear_right_dist;
      slot_id[2]   = SNS_REAR_RIGHT;
      slot_en[0]   = 1'b1;
      slot_en[1]   = 1'b1;
      slot_en[2]   = !rotating;
   end

   // Nearest valid sensor, gating and result codes.
   always_comb begin
      logic        any_valid;
      logic        none_usable;
      logic [15:0] best_dist;
      logic [2:0]  best_id;
      logic [15:0] stop_d;
      logic [15:0] slow_d;
      logic signed [16:0] lim17;
      logic signed [16:0] floor17;

      any_valid   = 1'b0;
      none_usable = 1'b1;
      best_dist   = '0;
      best_id     = SNS_NONE;
      stop_d      = rotating ? cfg.rotate_stop_dist : cfg.reverse_stop_dist;
      slow_d      = rotating ? cfg.rotate_slow_dist : cfg.reverse_slow_dist;
      lim17       = signed'({2'b00, cfg.rotate_speed_limit});
      floor17     = -signed'({2'b00, cfg.reverse_speed_limit});

      // Strictly nearer replaces, so ties keep the earlier sensor.
      for (int i = 0; i < 3; i++) begin
         if (slot_en[i]) begin
            if (!slot_st[i][1]) begin
               none_usable = 1'b0;
            end
            if (slot_st[i] == ST_VALID && (!any_valid || slot_dist[i] < best_dist)) begin
               any_valid = 1'b1;
               best_dist = slot_dist[i];
               best_id   = slot_id[i];
            end
         end
      end

      rsp.gated_linear    = req.linear_velocity;
      rsp.gated_angular   = req.angular_velocity;
      rsp.guard_mode      = MODE_IDLE;
      rsp.guard_action    = ACT_PASS;
      rsp.blocked         = 1'b0;
      rsp.deciding_sensor = SNS_NONE;
      rsp.nearest_dist    = '0;
      rsp.dist_known      = 1'b0;
      rsp.reason          = RSN_OK;

      if (rotating || reversing) begin
         // Mode for the guarded motions.
         if (rotating) begin
            rsp.guard_mode = left ? MODE_ROTATE_LEFT : MODE_ROTATE_RIGHT;
         end else if (ang17 > rot_db) begin
            rsp.guard_mode = MODE_REVERSE_LEFT;
         end else if (ang17 < -rot_db) begin
            rsp.guard_mode = MODE_REVERSE_RIGHT;
         end else begin
            rsp.guard_mode = MODE_REVERSE;
         end

         // Classify against the stop and slow distances.
         if (none_usable) begin
            rsp.guard_action    = ACT_STOP;
            rsp.blocked         = 1'b1;
            rsp.deciding_sensor = SNS_GROUP;
            rsp.reason          = RSN_ALLINV;
         end else if (!any_valid) begin
            rsp.deciding_sensor = SNS_GROUP;
            rsp.reason          = RSN_CLEAR;
         end else begin
            rsp.deciding_sensor = best_id;
            rsp.nearest_dist    = best_dist;
            rsp.dist_known      = 1'b1;
            if (best_dist <= stop_d) begin
               rsp.guard_action = ACT_STOP;
               rsp.blocked      = 1'b1;
               rsp.reason       = RSN_STOP;
            end else if (best_dist <= slow_d) begin
               rsp.guard_action = ACT_SLOW;
               rsp.reason       = RSN_SLOW;
            end else begin
               rsp.reason = RSN_CLEAR;
            end
         end

         // Gate only the velocity of the guarded motion.
         if (rsp.guard_action == ACT_STOP) begin
            if (rotating) begin
               rsp.gated_angular = '0;
            end else begin
               rsp.gated_linear = '0;
            end
         end else if (rsp.guard_action == ACT_SLOW) begin
            if (rotating) begin
               if (signed'(aang) > lim17) begin
                  rsp.gated_angular = ang17[16] ? 16'(-lim17) : 16'(lim17);
               end
            end else if (lin17 < floor17) begin
               rsp.gated_linear = floor17[15:0];
            end
         end
      end else if (alin >= {2'b00, cfg.drive_band}) begin
         rsp.guard_mode = MODE_FORWARD;
      end
   end

endmodule

@@ sv/motion_collision_guard.sv @@
`timescale 1ns / 1ps
// Top level of the motion collision guard: transfer pipeline around mcg_decide.
// Depends on mcg_pkg, mcg_csr and mcg_decide.
//
// Each accepted command and sensor snapshot produces exactly one guarded result,
// and a new snapshot can be accepted every cycle while req_stall is low. The
// snapshot is captured in an input register, judged by one pass of compare and
// select logic, and the result is held in an output register; req_stall rises
// only when both registers are full and rsp_stall holds the result. Configuration
// writes are always accepted and should be made while no transfer is in flight.
module motion_collision_guard #(
   parameter int BACKUP_BAND = 10
) (
   input  logic                              clock,
   input  logic                              reset,
   // Command and sensor snapshot
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [15:0]                req_linear_velocity,
   input  logic signed [15:0]                req_angular_velocity,
   input  logic [1:0]                        req_front_left_state,
   input  logic [15:0]                       req_front_left_dist,
   input  logic [1:0]                        req_front_right_state,
   input  logic [15:0]                       req_front_right_dist,
   input  logic [1:0]                        req_rear_center_state,
   input  logic [15:0]                       req_rear_center_dist,
   input  logic [1:0]                        req_rear_left_state,
   input  logic [15:0]                       req_rear_left_dist,
   input  logic [1:0]                        req_rear_right_state,
   input  logic [15:0]                       req_rear_right_dist,
   // Guarded result
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [15:0]                rsp_gated_linear,
   output logic signed [15:0]                rsp_gated_angular,
   output logic [2:0]                        rsp_guard_mode,
   output logic [1:0]                        rsp_guard_action,
   output logic                              rsp_blocked,
   output logic [2:0]                        rsp_deciding_sensor,
   output logic [15:0]                       rsp_nearest_dist,
   output logic                              rsp_dist_known,
   output logic [2:0]                        rsp_reason,
   // Configuration writes
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [mcg_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [mcg_pkg::CsrDataWidth-1:0]  csr_wdata
);
   import mcg_pkg::*;

   cfg_type cfg;
   req_type req_in;
   req_type req_ff;
   rsp_type rsp_in;
   rsp_type rsp_ff;
   logic    req_valid_ff;
   logic    rsp_valid_ff;
   logic    out_move;

   mcg_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Gather the snapshot ports into one word.
   always_comb begin
      req_in.linear_velocity   = req_linear_velocity;
      req_in.angular_velocity  = req_angular_velocity;
      req_in.front_left_state  = req_front_left_state;
      req_in.front_left_dist   = req_front_left_dist;
      req_in.front_right_state = req_front_right_state;
      req_in.front_right_dist  = req_front_right_dist;
      req_in.rear_center_state = req_rear_center_state;
      req_in.rear_center_dist  = req_rear_center_dist;
      req_in.rear_left_state   = req_rear_left_state;
      req_in.rear_left_dist    = req_rear_left_dist;
      req_in.rear_right_state  = req_rear_right_state;
      req_in.rear_right_dist   = req_rear_right_dist;
   end

   // The output register can load unless it holds a stalled result.
   assign out_move  = !(rsp_valid_ff && rsp_stall);
   assign req_stall = req_valid_ff && !out_move;

   // Input register stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         req_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         req_ff <= req_in;
      end
   end

   mcg_decide #(
      .BACKUP_BAND (BACKUP_BAND)
   ) u_decide (
      .req (req_ff),
      .cfg (cfg),
      .rsp (rsp_in)
   );

   // Result register stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_move) begin
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_move && req_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_gated_linear    = rsp_ff.gated_linear;
   assign rsp_gated_angular   = rsp_ff.gated_angular;
   assign rsp_guard_mode      = rsp_ff.guard_mode;
   assign rsp_guard_action    = rsp_ff.guard_action;
   assign rsp_blocked         = rsp_ff.blocked;
   assign rsp_deciding_sensor = rsp_ff.deciding_sensor;
   assign rsp_nearest_dist    = rsp_ff.nearest_dist;
   assign rsp_dist_known      = rsp_ff.dist_known;
   assign rsp_reason          = rsp_ff.reason;

endmodule
